>>> rtl/pdsu_pkg.sv
// Package for the PID differential speed update block.
// Holds the register map, reset values, configuration struct and fixed widths.
// No dependencies; imported by pdsu_datapath and the top level.
package pdsu_pkg;

    localparam int GAIN_BITS        = 10;
    localparam int START_BITS       = 16;
    localparam int SUM_BITS         = 32;
    localparam int APB_DATA_BITS    = 32;
    localparam int APB_ADDR_BITS    = 5;
    localparam int REG_INDEX_BITS   = 3;

    localparam int POSITION_BITS_DEFAULT = 12;
    localparam int SPEED_BITS_DEFAULT    = 16;

    localparam logic [GAIN_BITS-1:0]         GAIN_P_RESET      = 10'd10;
    localparam logic [GAIN_BITS-1:0]         GAIN_D_RESET      = 10'd450;
    localparam logic [GAIN_BITS-1:0]         GAIN_I_RESET      = 10'd1;
    localparam logic signed [START_BITS-1:0] START_SPEED_RESET = 16'sd1000;

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_GAIN_P            = 3'd0,
        REG_GAIN_D            = 3'd1,
        REG_GAIN_I            = 3'd2,
        REG_START_SPEED_RIGHT = 3'd3,
        REG_START_SPEED_LEFT  = 3'd4
    } reg_index_t;

    typedef enum logic {
        OP_STEP    = 1'b0,
        OP_RESTART = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0]         gain_p;
        logic [GAIN_BITS-1:0]         gain_d;
        logic [GAIN_BITS-1:0]         gain_i;
        logic signed [START_BITS-1:0] start_speed_right;
        logic signed [START_BITS-1:0] start_speed_left;
    } config_t;

endpackage

>>> rtl/pdsu_datapath.sv
// Combinational PID step: integral update, correction and speed saturation, or restart to the starting speeds.
// Depends on pdsu_pkg for the configuration struct, opcodes and fixed widths.
module pdsu_datapath
    import pdsu_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int SPEED_BITS    = SPEED_BITS_DEFAULT
)
(
    input  config_t                         cfg,
    input  opcode_t                         opcode,
    input  logic signed [POSITION_BITS-1:0] position,
    input  logic signed [POSITION_BITS-1:0] last_error,
    input  logic signed [SUM_BITS-1:0]      error_sum,
    input  logic signed [SPEED_BITS-1:0]    speed_right,
    input  logic signed [SPEED_BITS-1:0]    speed_left,
    output logic signed [POSITION_BITS-1:0] last_error_next,
    output logic signed [SUM_BITS-1:0]      error_sum_next,
    output logic signed [SPEED_BITS-1:0]    speed_right_next,
    output logic signed [SPEED_BITS-1:0]    speed_left_next
);

    localparam int PP_BITS   = POSITION_BITS + GAIN_BITS + 1;
    localparam int PD_BITS   = POSITION_BITS + GAIN_BITS + 2;
    localparam int PI_BITS   = SUM_BITS + GAIN_BITS + 1;
    localparam int MAX_TERM  = (PI_BITS > PD_BITS) ? PI_BITS : PD_BITS;
    localparam int CORR_BITS = MAX_TERM + 2;
    localparam int WIDE_BITS = CORR_BITS + 2;

    localparam logic signed [WIDE_BITS-1:0] SPEED_MAX =
        WIDE_BITS'((64'sd1 <<< (SPEED_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_BITS-1:0] SPEED_MIN = -SPEED_MAX - 1;

    logic signed [SUM_BITS:0]        sum_wide;
    logic signed [SUM_BITS-1:0]      sum_new;
    logic signed [POSITION_BITS:0]   diff;
    logic signed [PP_BITS-1:0]       prod_p;
    logic signed [PD_BITS-1:0]       prod_d;
    logic signed [PI_BITS-1:0]       prod_i;
    logic signed [CORR_BITS-1:0]     corr;
    logic signed [WIDE_BITS-1:0]     right_wide;
    logic signed [WIDE_BITS-1:0]     left_wide;

    function automatic logic signed [SPEED_BITS-1:0] sat_speed(
        input logic signed [WIDE_BITS-1:0] v
    );
        logic signed [SPEED_BITS-1:0] r;
        if (v > SPEED_MAX)
            r = SPEED_MAX[SPEED_BITS-1:0];
        else if (v < SPEED_MIN)
            r = SPEED_MIN[SPEED_BITS-1:0];
        else
            r = v[SPEED_BITS-1:0];
        return r;
    endfunction

    // The integral saturates when the two top bits of the widened sum disagree.
    assign sum_wide = (SUM_BITS+1)'(error_sum) + (SUM_BITS+1)'(position);
    always_comb
    begin
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
            sum_new = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                         : {1'b0, {(SUM_BITS-1){1'b1}}};
        else
            sum_new = sum_wide[SUM_BITS-1:0];
    end

    assign diff   = (POSITION_BITS+1)'(position) - (POSITION_BITS+1)'(last_error);
    assign prod_p = $signed({1'b0, cfg.gain_p}) * position;
    assign prod_d = $signed({1'b0, cfg.gain_d}) * diff;
    assign prod_i = $signed({1'b0, cfg.gain_i}) * sum_new;
    assign corr   = CORR_BITS'(prod_p) + CORR_BITS'(prod_d) + CORR_BITS'(prod_i);

    assign right_wide = WIDE_BITS'(speed_right) - WIDE_BITS'(corr);
    assign left_wide  = WIDE_BITS'(speed_left) + WIDE_BITS'(corr);

    always_comb
    begin
        if (opcode == OP_RESTART)
        begin
            last_error_next  = '0;
            error_sum_next   = '0;
            speed_right_next = sat_speed(WIDE_BITS'(cfg.start_speed_right));
            speed_left_next  = sat_speed(WIDE_BITS'(cfg.start_speed_left));
        end
        else
        begin
            last_error_next  = position;
            error_sum_next   = sum_new;
            speed_right_next = sat_speed(right_wide);
            speed_left_next  = sat_speed(left_wide);
        end
    end

endmodule

>>> rtl/pid_differential_speed_update_core.sv
// Top level of the PID differential speed update block: stream ports, APB registers,
// input stage and controller state. Depends on pdsu_pkg and pdsu_datapath.
//
// Each accepted transaction carries an opcode and a signed line-position error. A step
// transaction updates the saturating error integral, forms
// gain_p*err + gain_d*(err - last err) + gain_i*integral, subtracts it from the right
// speed and adds it to the left speed, both saturated to SPEED_BITS; a restart
// transaction clears the error state and loads the configured starting speeds. Every
// transaction yields one result holding both new speeds. The input register loads at the
// accepting edge, the state and result register when the input stage moves on, which waits
// while a result is held and not taken. One transaction is accepted per cycle while results
// are taken; the rate is set by the update of the shared controller state. Registers
// should be written only while the block is idle.
module pid_differential_speed_update_core
    import pdsu_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int SPEED_BITS    = SPEED_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [APB_ADDR_BITS-1:0]          paddr,
    input  logic [APB_DATA_BITS-1:0]          pwdata,
    output logic [APB_DATA_BITS-1:0]          prdata,
    output logic                              pready,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // position, zero padded to whole bytes
    input  logic [((POSITION_BITS+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  logic                              s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // speed_right (low), speed_left, zero padded to whole bytes
    output logic [((2*SPEED_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_DATA_BITS = ((2 * SPEED_BITS + 7) / 8) * 8;

    localparam logic signed [SPEED_BITS-1:0] SPEED_MAX =
        SPEED_BITS'((64'sd1 <<< (SPEED_BITS - 1)) - 64'sd1);
    localparam logic signed [SPEED_BITS-1:0] SPEED_RESET =
        (64'(START_SPEED_RESET) > 64'(SPEED_MAX)) ? SPEED_MAX
                                                 : SPEED_BITS'(START_SPEED_RESET);

    config_t                         cfg_reg;
    logic                            cfg_write;
    reg_index_t                      reg_index;

    logic                            in_valid_reg;
    opcode_t                         opcode_reg;
    logic signed [POSITION_BITS-1:0] position_reg;
    logic                            out_valid_reg;

    logic signed [POSITION_BITS-1:0] last_error_reg;
    logic signed [SUM_BITS-1:0]      error_sum_reg;
    logic signed [SPEED_BITS-1:0]    speed_right_reg;
    logic signed [SPEED_BITS-1:0]    speed_left_reg;

    logic signed [POSITION_BITS-1:0] last_error_next;
    logic signed [SUM_BITS-1:0]      error_sum_next;
    logic signed [SPEED_BITS-1:0]    speed_right_next;
    logic signed [SPEED_BITS-1:0]    speed_left_next;

    logic                            advance;
    logic                            in_accept;

    // Configuration registers.
    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[APB_ADDR_BITS-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p            <= GAIN_P_RESET;
            cfg_reg.gain_d            <= GAIN_D_RESET;
            cfg_reg.gain_i            <= GAIN_I_RESET;
            cfg_reg.start_speed_right <= START_SPEED_RESET;
            cfg_reg.start_speed_left  <= START_SPEED_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_GAIN_P:            cfg_reg.gain_p <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_D:            cfg_reg.gain_d <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_I:            cfg_reg.gain_i <= pwdata[GAIN_BITS-1:0];
                REG_START_SPEED_RIGHT: cfg_reg.start_speed_right <= pwdata[START_BITS-1:0];
                REG_START_SPEED_LEFT:  cfg_reg.start_speed_left <= pwdata[START_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_GAIN_P:            prdata = APB_DATA_BITS'(cfg_reg.gain_p);
            REG_GAIN_D:            prdata = APB_DATA_BITS'(cfg_reg.gain_d);
            REG_GAIN_I:            prdata = APB_DATA_BITS'(cfg_reg.gain_i);
            REG_START_SPEED_RIGHT: prdata = APB_DATA_BITS'(cfg_reg.start_speed_right);
            REG_START_SPEED_LEFT:  prdata = APB_DATA_BITS'(cfg_reg.start_speed_left);
            default:               prdata = '0;
        endcase
    end

    // The input stage moves on when the result register is empty or being drained.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            opcode_reg   <= opcode_t'(s_axis_tuser);
            position_reg <= s_axis_tdata[POSITION_BITS-1:0];
        end
    end

    pdsu_datapath #(
        .POSITION_BITS (POSITION_BITS),
        .SPEED_BITS    (SPEED_BITS)
    ) u_datapath (
        .cfg              (cfg_reg),
        .opcode           (opcode_reg),
        .position         (position_reg),
        .last_error       (last_error_reg),
        .error_sum        (error_sum_reg),
        .speed_right      (speed_right_reg),
        .speed_left       (speed_left_reg),
        .last_error_next  (last_error_next),
        .error_sum_next   (error_sum_next),
        .speed_right_next (speed_right_next),
        .speed_left_next  (speed_left_next)
    );

    // The speed state doubles as the result register: it only changes when the
    // previous result has been taken or is being taken in the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg  <= '0;
            error_sum_reg   <= '0;
            speed_right_reg <= SPEED_RESET;
            speed_left_reg  <= SPEED_RESET;
        end
        else if (advance)
        begin
            last_error_reg  <= last_error_next;
            error_sum_reg   <= error_sum_next;
            speed_right_reg <= speed_right_next;
            speed_left_reg  <= speed_left_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'({speed_left_reg, speed_right_reg});

endmodule
